// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the timer bank.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a condition at every clock edge outside of reset.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// Checks that a consequent holds in the same cycle as its antecedent.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/mctb_pkg.sv =====
// Shared types, codes and default sizes of the multi-channel timer bank.
`timescale 1ns / 1ps
`default_nettype none

package mctb_pkg;

    localparam int SLOTS_DEF     = 8;
    localparam int TIME_BITS_DEF = 48;

    localparam int OP_W     = 3;
    localparam int HANDLE_W = 4;
    localparam int IVL_W    = 32;
    localparam int ST_W     = 2;

    localparam logic [OP_W-1:0] OP_TICK       = 3'd0;
    localparam logic [OP_W-1:0] OP_REGISTER   = 3'd1;
    localparam logic [OP_W-1:0] OP_DEREGISTER = 3'd2;
    localparam logic [OP_W-1:0] OP_START      = 3'd3;
    localparam logic [OP_W-1:0] OP_STOP       = 3'd4;

    localparam logic KIND_ACK  = 1'b0;
    localparam logic KIND_FIRE = 1'b1;

    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_NO_TIMER = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL     = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [HANDLE_W-1:0] handle;
        logic [IVL_W-1:0]    interval;
        logic                mode;
    } s_item_t;

    typedef struct packed {
        logic                kind;
        logic [HANDLE_W-1:0] handle_out;
        logic [ST_W-1:0]     status;
        logic                last;
    } m_item_t;

endpackage

`default_nettype wire

// ===== rtl/mctb_slot_mem.sv =====
// Slot memories holding deadlines and interval/mode pairs, with a registered read.
`timescale 1ns / 1ps
`default_nettype none

module mctb_slot_mem
    import mctb_pkg::*;
#(
    parameter int SLOTS     = SLOTS_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF,
    parameter int IDX_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  wire logic                 aclk,
    input  wire logic [IDX_W-1:0]     rd_addr,
    input  wire logic                 wr_dl_en,
    input  wire logic                 wr_par_en,
    input  wire logic [IDX_W-1:0]     wr_addr,
    input  wire logic [TIME_BITS-1:0] wr_deadline,
    input  wire logic [IVL_W-1:0]     wr_interval,
    input  wire logic                 wr_cont,
    output logic [TIME_BITS-1:0]      rd_deadline,
    output logic [IVL_W-1:0]          rd_interval,
    output logic                      rd_cont
);

    logic [TIME_BITS-1:0] dl_mem [SLOTS];
    logic [IVL_W:0]       par_mem [SLOTS];

    always_ff @(posedge aclk) begin
        if (wr_dl_en) begin
            dl_mem[wr_addr] <= wr_deadline;
        end
        if (wr_par_en) begin
            par_mem[wr_addr] <= {wr_cont, wr_interval};
        end
    end

    always_ff @(posedge aclk) begin
        rd_deadline                <= dl_mem[rd_addr];
        {rd_cont, rd_interval}     <= par_mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== rtl/multi_channel_timer_bank.sv =====
// Top level of the multi-channel timer bank: request decoding, tick scan and result output.
//
//   Channel   Ports                     Direction   Carries
//   s_        s_valid s_ready s_item    in          one request (op, handle, interval, mode)
//   m_        m_valid m_ready m_item    out         acknowledge or fire result
//
// Register, deregister, stop go via S_ACK; start on a known handle goes via S_START, then S_ACK.
// A tick makes one scan pass per fired slot plus a final one, each pass reading the
// deadline memory once per slot.
// Requests are taken one at a time; s_ready is high only while the bank is idle.
// A stalled output holds the bank at its next result. aresetn frees and disarms all slots.
`timescale 1ns / 1ps
`default_nettype none

module multi_channel_timer_bank
    import mctb_pkg::*;
#(
    parameter int SLOTS     = SLOTS_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    input  wire s_item_t s_item,
    output logic         m_valid,
    input  wire logic    m_ready,
    output m_item_t      m_item
);

`include "assert_macros.svh"

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int EXT_W = (IDX_W > HANDLE_W) ? IDX_W : HANDLE_W;
    localparam int SUM_W = ((TIME_BITS > IVL_W) ? TIME_BITS : IVL_W) + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_PICK,
        S_START,
        S_ACK
    } state_t;

    state_t               state_reg;
    logic [TIME_BITS-1:0] now_reg;
    logic [SLOTS-1:0]     valid_reg;
    logic [SLOTS-1:0]     armed_reg;
    logic [SLOTS-1:0]     due_reg;
    logic                 first_pass_reg;
    logic [CNT_W-1:0]     scan_cnt_reg;
    logic                 tag_valid_reg;
    logic [IDX_W-1:0]     tag_idx_reg;
    logic                 best_found_reg;
    logic [IDX_W-1:0]     best_idx_reg;
    logic [TIME_BITS-1:0] best_dl_reg;
    logic [IVL_W-1:0]     best_ivl_reg;
    logic                 best_cont_reg;
    logic                 pend_valid_reg;
    logic [IDX_W-1:0]     pend_idx_reg;
    logic [IDX_W-1:0]     slot_idx_reg;
    m_item_t              ack_item_reg;
    m_item_t              ack_item_next;
    logic                 m_valid_reg;
    logic                 m_valid_next;
    m_item_t              m_item_reg;

    logic                 accept;
    logic                 out_free;
    logic                 pick_go;
    logic                 any_free;
    logic [IDX_W-1:0]     free_idx;
    logic [EXT_W-1:0]     h_ext;
    logic [IDX_W-1:0]     h_idx;
    logic                 h_known;
    logic [IDX_W-1:0]     rd_addr;
    logic                 wr_dl_en;
    logic                 wr_par_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [TIME_BITS-1:0] rd_deadline;
    logic [IVL_W-1:0]     rd_interval;
    logic                 rd_cont;
    logic [IVL_W-1:0]     ivl_sel;
    logic [SUM_W-1:0]     sum;
    logic [TIME_BITS-1:0] sat_sum;
    logic                 cand;
    logic                 better;

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_item   = m_item_reg;
    assign out_free = !m_valid_reg || m_ready;
    assign pick_go  = !pend_valid_reg || out_free;

    assign m_valid_next = ((state_reg == S_PICK) && pick_go && pend_valid_reg)
                          || ((state_reg == S_ACK) && out_free)
                          || (m_valid_reg && !m_ready);

    always_comb begin
        any_free = 1'b0;
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                any_free = 1'b1;
                free_idx = IDX_W'(i);
            end
        end
    end

    assign h_ext   = EXT_W'(s_item.handle) - EXT_W'(1);
    assign h_idx   = h_ext[IDX_W-1:0];
    assign h_known = (s_item.handle != '0) && (32'(s_item.handle) <= 32'(SLOTS))
                     && valid_reg[h_idx];

    always_comb begin
        ack_item_next.kind = KIND_ACK;
        ack_item_next.last = 1'b1;
        if (s_item.op == OP_REGISTER) begin
            ack_item_next.handle_out = any_free ? HANDLE_W'(32'(free_idx) + 32'd1) : '0;
            ack_item_next.status     = any_free ? ST_OK : ST_FULL;
        end else begin
            ack_item_next.handle_out = s_item.handle;
            ack_item_next.status     = h_known ? ST_OK : ST_NO_TIMER;
        end
    end

    assign ivl_sel = (state_reg == S_START) ? rd_interval : best_ivl_reg;
    assign sum     = SUM_W'(now_reg) + SUM_W'(ivl_sel);
    assign sat_sum = (|sum[SUM_W-1:TIME_BITS]) ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];

    assign rd_addr   = (state_reg == S_SCAN) ? scan_cnt_reg[IDX_W-1:0] : h_idx;
    assign wr_par_en = accept && (s_item.op == OP_REGISTER) && any_free;
    assign wr_dl_en  = (state_reg == S_START)
                       || ((state_reg == S_PICK) && pick_go && best_found_reg && best_cont_reg);

    always_comb begin
        unique case (state_reg)
            S_PICK:  wr_addr = best_idx_reg;
            S_START: wr_addr = slot_idx_reg;
            default: wr_addr = free_idx;
        endcase
    end

    assign cand   = first_pass_reg
                    ? (valid_reg[tag_idx_reg] && armed_reg[tag_idx_reg] && (rd_deadline <= now_reg))
                    : due_reg[tag_idx_reg];
    assign better = cand && (!best_found_reg || (rd_deadline < best_dl_reg));

    mctb_slot_mem #(
        .SLOTS     (SLOTS),
        .TIME_BITS (TIME_BITS),
        .IDX_W     (IDX_W)
    ) u_slot_mem (
        .aclk        (aclk),
        .rd_addr     (rd_addr),
        .wr_dl_en    (wr_dl_en),
        .wr_par_en   (wr_par_en),
        .wr_addr     (wr_addr),
        .wr_deadline (sat_sum),
        .wr_interval (s_item.interval),
        .wr_cont     (s_item.mode),
        .rd_deadline (rd_deadline),
        .rd_interval (rd_interval),
        .rd_cont     (rd_cont)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            now_reg        <= '0;
            valid_reg      <= '0;
            armed_reg      <= '0;
            due_reg        <= '0;
            first_pass_reg <= 1'b0;
            scan_cnt_reg   <= '0;
            tag_valid_reg  <= 1'b0;
            best_found_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        ack_item_reg <= ack_item_next;
                        unique case (s_item.op)
                            OP_TICK: begin
                                if (now_reg != {TIME_BITS{1'b1}}) begin
                                    now_reg <= now_reg + TIME_BITS'(1);
                                end
                                first_pass_reg <= 1'b1;
                                pend_valid_reg <= 1'b0;
                                best_found_reg <= 1'b0;
                                scan_cnt_reg   <= '0;
                                tag_valid_reg  <= 1'b0;
                                state_reg      <= S_SCAN;
                            end
                            OP_REGISTER: begin
                                if (any_free) begin
                                    valid_reg[free_idx] <= 1'b1;
                                    armed_reg[free_idx] <= 1'b0;
                                end
                                state_reg <= S_ACK;
                            end
                            OP_DEREGISTER: begin
                                if (h_known) begin
                                    valid_reg[h_idx] <= 1'b0;
                                    armed_reg[h_idx] <= 1'b0;
                                end
                                state_reg <= S_ACK;
                            end
                            OP_START: begin
                                slot_idx_reg <= h_idx;
                                state_reg    <= h_known ? S_START : S_ACK;
                            end
                            OP_STOP: begin
                                if (h_known) begin
                                    armed_reg[h_idx] <= 1'b0;
                                end
                                state_reg <= S_ACK;
                            end
                            default: begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (scan_cnt_reg != CNT_W'(SLOTS)) begin
                        scan_cnt_reg <= scan_cnt_reg + CNT_W'(1);
                    end
                    tag_valid_reg <= (scan_cnt_reg != CNT_W'(SLOTS));
                    tag_idx_reg   <= scan_cnt_reg[IDX_W-1:0];
                    if (tag_valid_reg) begin
                        if (first_pass_reg) begin
                            due_reg[tag_idx_reg] <= cand;
                        end
                        if (better) begin
                            best_found_reg <= 1'b1;
                            best_idx_reg   <= tag_idx_reg;
                            best_dl_reg    <= rd_deadline;
                            best_ivl_reg   <= rd_interval;
                            best_cont_reg  <= rd_cont;
                        end
                    end
                    if ((scan_cnt_reg == CNT_W'(SLOTS)) && !tag_valid_reg) begin
                        state_reg <= S_PICK;
                    end
                end
                S_PICK: begin
                    if (pick_go) begin
                        if (pend_valid_reg) begin
                            m_item_reg.kind       <= KIND_FIRE;
                            m_item_reg.handle_out <= HANDLE_W'(32'(pend_idx_reg) + 32'd1);
                            m_item_reg.status     <= ST_OK;
                            m_item_reg.last       <= !best_found_reg;
                        end
                        if (best_found_reg) begin
                            due_reg[best_idx_reg] <= 1'b0;
                            if (!best_cont_reg) begin
                                armed_reg[best_idx_reg] <= 1'b0;
                            end
                            pend_valid_reg <= 1'b1;
                            pend_idx_reg   <= best_idx_reg;
                            first_pass_reg <= 1'b0;
                            best_found_reg <= 1'b0;
                            scan_cnt_reg   <= '0;
                            tag_valid_reg  <= 1'b0;
                            state_reg      <= S_SCAN;
                        end else begin
                            pend_valid_reg <= 1'b0;
                            state_reg      <= S_IDLE;
                        end
                    end
                end
                S_START: begin
                    armed_reg[slot_idx_reg] <= 1'b1;
                    state_reg               <= S_ACK;
                end
                S_ACK: begin
                    if (out_free) begin
                        m_item_reg <= ack_item_reg;
                        state_reg  <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `ASSERT_ALWAYS(a_armed_needs_valid, (armed_reg & ~valid_reg) == '0, "armed slot is not registered")
    `ASSERT_IMPLIES(a_idle_no_pending, state_reg == S_IDLE, !pend_valid_reg, "fire result left pending in idle")
    `ASSERT_IMPLIES(a_due_is_armed, (state_reg == S_SCAN) && !first_pass_reg, (due_reg & ~armed_reg) == '0, "due slot is not armed")

endmodule

`default_nettype wire
